// ===== design/pmmt_pkg.sv =====
// shared types, constants and helpers for the per-sensor min/max/mean table
// no dependencies; imported by pmmt_div and per_sensor_min_max_mean_table
`default_nettype none
package pmmt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int ID_WIDTH    = 32;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int OUT_ID_W    = 32;
   localparam int SUM_W       = 96;
   localparam int DIV_STEPS   = SUM_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_SET    = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_TICK   = 2'd3;

   localparam logic [1:0] KIND_INT32  = 2'd0;
   localparam logic [1:0] KIND_UINT32 = 2'd1;
   localparam logic [1:0] KIND_INT64  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ZERO_ID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic RSP_ACK    = 1'b0;
   localparam logic RSP_RECORD = 1'b1;

   typedef struct packed {
      logic                   go;
      logic [SUM_W-1:0]       dividend;
      logic [31:0]            divisor;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic [63:0]            quotient;
   } div_rsp_type;

   // raw sample bits to a signed 64-bit value per registered type
   function automatic logic [63:0] to_sample(input logic [1:0] k, input logic [63:0] b);
      logic [63:0] r;
      case (k)
         KIND_INT32:  r = {{32{b[31]}}, b[31:0]};
         KIND_UINT32: r = {32'd0, b[31:0]};
         KIND_INT64:  r = b;
         default:     r = b[63] ? 64'h7FFF_FFFF_FFFF_FFFF : b;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/pmmt_div.sv =====
// shared restoring divider: signed 96-bit sum by unsigned 32-bit count, one bit per cycle
// depends on pmmt_pkg
`default_nettype none
module pmmt_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  pmmt_pkg::div_req_type     div_req,
   output pmmt_pkg::div_rsp_type     div_rsp
);
   import pmmt_pkg::*;

   logic              run_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [SUM_W-1:0]  num_ff;
   logic [31:0]       rem_ff;
   logic [31:0]       den_ff;
   logic [63:0]       quo_ff;
   logic              neg_ff;
   logic              done_ff;
   logic [63:0]       result_ff;

   logic [32:0]       trial;
   logic              q_bit;
   logic [32:0]       diff;
   logic [63:0]       quo_in;

   always_comb begin
      trial  = {rem_ff, num_ff[SUM_W-1]};
      diff   = trial - {1'b0, den_ff};
      q_bit  = (trial >= {1'b0, den_ff});
      quo_in = {quo_ff[62:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.go) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.go) begin
         neg_ff <= div_req.dividend[SUM_W-1];
         num_ff <= div_req.dividend[SUM_W-1] ? (~div_req.dividend + 1'b1) : div_req.dividend;
         den_ff <= div_req.divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (run_ff) begin
         rem_ff <= q_bit ? diff[31:0] : trial[31:0];
         num_ff <= {num_ff[SUM_W-2:0], 1'b0};
         quo_ff <= quo_in;
         if (cnt_ff == STEP_W'(DIV_STEPS - 1))
            result_ff <= neg_ff ? (~quo_in + 1'b1) : quo_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = result_ff;

endmodule
`default_nettype wire

// ===== design/per_sensor_min_max_mean_table.sv =====
// sample/set: accept, scan of all TABLE_DEPTH slots, update in S_EXEC; set acks the cycle after
// clear all: accept, update in S_EXEC, ack the cycle after; tick: S_TICK steps past slots with no
// data, a record per slot with data after the 96-step shared divider; busy meanwhile
// results are one-cycle strobes on rsp_valid; the receiver cannot stall
// synchronous reset empties the table and clears every count
`default_nettype none
module per_sensor_min_max_mean_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_source_id,
   input  wire logic [63:0] req_sample_bits,
   input  wire logic [2:0]  req_sensor_type,
   input  wire logic [31:0] req_target_id,
   output logic             rsp_valid,
   output logic             rsp_kind,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_out_id,
   output logic [63:0]      rsp_min_value,
   output logic [63:0]      rsp_avg_value,
   output logic [63:0]      rsp_max_value,
   output logic             rsp_last
);
   import pmmt_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_TICK, S_DIV} state_type;

   state_type               state_ff;
   logic [IDX_W-1:0]        slot_ff;
   logic                    hit_ff, free_ff;
   logic [IDX_W-1:0]        hit_idx_ff, free_idx_ff;
   logic [1:0]              cmd_ff;
   logic [ID_WIDTH-1:0]     id_ff, target_ff;
   logic [63:0]             bits_ff;
   logic [2:0]              type_ff;
   logic [TABLE_DEPTH-1:0]  mask_ff;

   logic [TABLE_DEPTH-1:0]  valid_ff;
   logic [31:0]             count_ff [TABLE_DEPTH];
   logic [ID_WIDTH-1:0]     source_ff [TABLE_DEPTH];
   logic [ID_WIDTH-1:0]     dest_ff [TABLE_DEPTH];
   logic [1:0]              kind_ff [TABLE_DEPTH];
   logic [63:0]             min_ff [TABLE_DEPTH];
   logic [63:0]             max_ff [TABLE_DEPTH];
   logic [SUM_W-1:0]        sum_ff [TABLE_DEPTH];

   logic                    rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [1:0]              rsp_status_ff;
   logic [31:0]             rsp_out_id_ff;
   logic [63:0]             rsp_min_ff, rsp_avg_ff, rsp_max_ff;

   div_req_type             div_req_ff;
   div_rsp_type             div_rsp;

   logic [63:0]             cur_v;
   logic [31:0]             cur_cnt;
   logic                    sample_go, set_ok, set_remove, set_write, set_new;
   logic [IDX_W-1:0]        set_slot;
   logic [1:0]              set_status;
   logic [TABLE_DEPTH-1:0]  slot_bit, data_mask, mask_in;

   pmmt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   always_comb begin
      cur_v      = to_sample(kind_ff[hit_idx_ff], bits_ff);
      cur_cnt    = count_ff[hit_idx_ff];
      sample_go  = (state_ff == S_EXEC) && (cmd_ff == CMD_SAMPLE) && hit_ff;
      set_ok     = (state_ff == S_EXEC) && (cmd_ff == CMD_SET) && (id_ff != '0);
      set_remove = set_ok && type_ff[2];
      set_write  = set_ok && !type_ff[2] && (hit_ff || free_ff);
      set_new    = set_write && !hit_ff;
      set_slot   = hit_ff ? hit_idx_ff : free_idx_ff;
      if (id_ff == '0)
         set_status = STATUS_ZERO_ID;
      else if (!type_ff[2] && !hit_ff && !free_ff)
         set_status = STATUS_FULL;
      else
         set_status = STATUS_OK;
      slot_bit = TABLE_DEPTH'(1) << slot_ff;
      mask_in  = mask_ff & ~slot_bit;
      for (int k = 0; k < TABLE_DEPTH; k++)
         data_mask[k] = valid_ff[k] && (count_ff[k] != '0);
   end

   // accumulators and descriptors, no reset
   always_ff @(posedge clock) begin
      if (sample_go) begin
         if (cur_cnt == '0) begin
            min_ff[hit_idx_ff] <= cur_v;
            max_ff[hit_idx_ff] <= cur_v;
            sum_ff[hit_idx_ff] <= {{(SUM_W-64){cur_v[63]}}, cur_v};
         end else begin
            if ($signed(cur_v) < $signed(min_ff[hit_idx_ff]))
               min_ff[hit_idx_ff] <= cur_v;
            if ($signed(max_ff[hit_idx_ff]) < $signed(cur_v))
               max_ff[hit_idx_ff] <= cur_v;
            if (cur_cnt != '1)
               sum_ff[hit_idx_ff] <= sum_ff[hit_idx_ff] + {{(SUM_W-64){cur_v[63]}}, cur_v};
         end
      end
      if (set_write) begin
         kind_ff[set_slot] <= type_ff[1:0];
         dest_ff[set_slot] <= target_ff;
         if (set_new)
            source_ff[set_slot] <= id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         for (int k = 0; k < TABLE_DEPTH; k++)
            count_ff[k] <= '0;
         rsp_valid_ff <= 1'b0;
         div_req_ff.go <= 1'b0;
         slot_ff      <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         mask_ff      <= '0;
      end else begin
         rsp_valid_ff  <= 1'b0;
         div_req_ff.go <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cmd_ff    <= req_cmd;
                  id_ff     <= req_source_id[ID_WIDTH-1:0];
                  bits_ff   <= req_sample_bits;
                  type_ff   <= req_sensor_type;
                  target_ff <= req_target_id[ID_WIDTH-1:0];
                  slot_ff   <= '0;
                  hit_ff    <= 1'b0;
                  free_ff   <= 1'b0;
                  mask_ff   <= data_mask;
                  case (req_cmd)
                     CMD_SAMPLE, CMD_SET: state_ff <= S_SCAN;
                     CMD_CLEAR:           state_ff <= S_EXEC;
                     default:             state_ff <= S_TICK;
                  endcase
               end
            end
            S_SCAN: begin
               if (valid_ff[slot_ff] && (source_ff[slot_ff] == id_ff)) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= slot_ff;
               end
               if (!valid_ff[slot_ff] && !free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= slot_ff;
               end
               if (slot_ff == IDX_W'(TABLE_DEPTH - 1))
                  state_ff <= S_EXEC;
               else
                  slot_ff <= slot_ff + 1'b1;
            end
            S_EXEC: begin
               state_ff <= S_IDLE;
               if (sample_go) begin
                  if (cur_cnt == '0)
                     count_ff[hit_idx_ff] <= 32'd1;
                  else if (cur_cnt != '1)
                     count_ff[hit_idx_ff] <= cur_cnt + 1'b1;
               end
               if (set_remove && hit_ff) begin
                  valid_ff[hit_idx_ff] <= 1'b0;
                  count_ff[hit_idx_ff] <= '0;
               end
               if (set_new) begin
                  valid_ff[free_idx_ff] <= 1'b1;
                  count_ff[free_idx_ff] <= '0;
               end
               if (cmd_ff == CMD_CLEAR) begin
                  valid_ff <= '0;
                  for (int k = 0; k < TABLE_DEPTH; k++)
                     count_ff[k] <= '0;
               end
               if (cmd_ff == CMD_SET || cmd_ff == CMD_CLEAR) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_kind_ff   <= RSP_ACK;
                  rsp_status_ff <= (cmd_ff == CMD_SET) ? set_status : STATUS_OK;
                  rsp_out_id_ff <= '0;
                  rsp_min_ff    <= '0;
                  rsp_avg_ff    <= '0;
                  rsp_max_ff    <= '0;
                  rsp_last_ff   <= 1'b1;
               end
            end
            S_TICK: begin
               if (mask_ff == '0) begin
                  for (int k = 0; k < TABLE_DEPTH; k++)
                     count_ff[k] <= '0;
                  state_ff <= S_IDLE;
               end else if (mask_ff[slot_ff]) begin
                  div_req_ff.go       <= 1'b1;
                  div_req_ff.dividend <= sum_ff[slot_ff];
                  div_req_ff.divisor  <= count_ff[slot_ff];
                  state_ff            <= S_DIV;
               end else begin
                  slot_ff <= slot_ff + 1'b1;
               end
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_kind_ff   <= RSP_RECORD;
                  rsp_status_ff <= STATUS_OK;
                  rsp_out_id_ff <= OUT_ID_W'(dest_ff[slot_ff]);
                  rsp_min_ff    <= min_ff[slot_ff];
                  rsp_avg_ff    <= div_rsp.quotient;
                  rsp_max_ff    <= max_ff[slot_ff];
                  rsp_last_ff   <= (mask_in == '0);
                  mask_ff       <= mask_in;
                  if (mask_in == '0) begin
                     for (int k = 0; k < TABLE_DEPTH; k++)
                        count_ff[k] <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     slot_ff  <= slot_ff + 1'b1;
                     state_ff <= S_TICK;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_id    = rsp_out_id_ff;
   assign rsp_min_value = rsp_min_ff;
   assign rsp_avg_value = rsp_avg_ff;
   assign rsp_max_value = rsp_max_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   // a word only comes out of a command in flight
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff != S_IDLE))
      else $error("result word without a command in flight");
   // acknowledges are always the single, final word
   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == RSP_ACK) |-> rsp_last)
      else $error("acknowledge without last");
   // a record follows a finished division
   a_record_after_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == RSP_RECORD) |-> $past(div_rsp.done))
      else $error("record without divider result");
   // divider only launched for a slot that has data
   a_div_has_data: assert property (@(posedge clock) disable iff (reset)
      div_req_ff.go |-> (div_req_ff.divisor != '0))
      else $error("divide by zero count");
`endif

endmodule
`default_nettype wire

// ===== test/per_sensor_min_max_mean_table_test.sv =====
// testbench for per_sensor_min_max_mean_table: a queue-fed driver, a strobe monitor and a
// behavioral table predictor checked field by field; depends on pmmt_pkg and the design
`timescale 1ns / 1ps
`default_nettype none
module per_sensor_min_max_mean_table_test;
   import pmmt_pkg::*;

   localparam int LIMIT_CYCLES = 5000000;

   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] source_id;
      logic [63:0] sample_bits;
      logic [2:0]  sensor_type;
      logic [31:0] target_id;
   } word_type;

   typedef struct {
      logic        kind;
      logic [1:0]  status;
      logic [31:0] out_id;
      logic [63:0] min_value;
      logic [63:0] avg_value;
      logic [63:0] max_value;
      logic        last;
   } result_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0]  req_cmd = '0;
   logic [31:0] req_source_id = '0;
   logic [63:0] req_sample_bits = '0;
   logic [2:0]  req_sensor_type = '0;
   logic [31:0] req_target_id = '0;
   logic        rsp_valid, rsp_kind, rsp_last;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_out_id;
   logic [63:0] rsp_min_value, rsp_avg_value, rsp_max_value;

   per_sensor_min_max_mean_table dut (.*);

   always #10 clock = ~clock;

   word_type   pending_words[$];
   result_type expected_results[$];
   int      failures = 0;
   int      cycle_count = 0;
   int      gap_left = 0;
   bit      stimulus_done = 0;

   // predictor copy of the table
   logic        tbl_valid[TABLE_DEPTH];
   logic [31:0] tbl_source[TABLE_DEPTH];
   logic [31:0] tbl_target[TABLE_DEPTH];
   logic [1:0]  tbl_kind[TABLE_DEPTH];
   logic [31:0] tbl_count[TABLE_DEPTH];
   logic [63:0] tbl_min[TABLE_DEPTH];
   logic [63:0] tbl_max[TABLE_DEPTH];
   logic [95:0] tbl_sum[TABLE_DEPTH];

   function automatic logic [63:0] sample_value(logic [1:0] k, logic [63:0] b);
      case (k)
         KIND_INT32:  return {{32{b[31]}}, b[31:0]};
         KIND_UINT32: return {32'd0, b[31:0]};
         KIND_INT64:  return b;
         default:     return b[63] ? 64'h7FFF_FFFF_FFFF_FFFF : b;
      endcase
   endfunction

   function automatic int lookup_slot(logic [31:0] id);
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (tbl_valid[i] && tbl_source[i] == id) return i;
      return -1;
   endfunction

   task automatic push_ack(logic [1:0] st);
      result_type r;
      r = '{RSP_ACK, st, 32'd0, 64'd0, 64'd0, 64'd0, 1'b1};
      expected_results.push_back(r);
   endtask

   task automatic predict_word(word_type w);
      int s;
      int n;
      logic [63:0] v;
      logic signed [96:0] sx, cx, q;
      result_type r;
      n = 0;
      case (w.cmd)
         CMD_SAMPLE: begin
            s = lookup_slot(w.source_id);
            if (s >= 0) begin
               v = sample_value(tbl_kind[s], w.sample_bits);
               if (tbl_count[s] == 0) begin
                  tbl_min[s] = v;
                  tbl_max[s] = v;
                  tbl_sum[s] = {{32{v[63]}}, v};
                  tbl_count[s] = 1;
               end else begin
                  if ($signed(v) < $signed(tbl_min[s])) tbl_min[s] = v;
                  if ($signed(v) > $signed(tbl_max[s])) tbl_max[s] = v;
                  if (tbl_count[s] != 32'hFFFF_FFFF) begin
                     tbl_sum[s] = tbl_sum[s] + {{32{v[63]}}, v};
                     tbl_count[s] = tbl_count[s] + 1;
                  end
               end
            end
         end
         CMD_SET: begin
            if (w.source_id == 0) push_ack(STATUS_ZERO_ID);
            else if (w.sensor_type[2]) begin
               s = lookup_slot(w.source_id);
               if (s >= 0) begin
                  tbl_valid[s] = 0;
                  tbl_count[s] = 0;
               end
               push_ack(STATUS_OK);
            end else begin
               s = lookup_slot(w.source_id);
               if (s < 0) begin
                  for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                     if (!tbl_valid[i]) s = i;
                  if (s >= 0) begin
                     tbl_valid[s] = 1;
                     tbl_source[s] = w.source_id;
                     tbl_count[s] = 0;
                  end
               end
               if (s >= 0) begin
                  tbl_kind[s] = w.sensor_type[1:0];
                  tbl_target[s] = w.target_id;
                  push_ack(STATUS_OK);
               end else push_ack(STATUS_FULL);
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               tbl_valid[i] = 0;
               tbl_count[i] = 0;
            end
            push_ack(STATUS_OK);
         end
         default: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (tbl_valid[i] && tbl_count[i] != 0) begin
                  sx = {tbl_sum[i][95], tbl_sum[i]};
                  cx = {65'd0, tbl_count[i]};
                  q = sx / cx;
                  r = '{RSP_RECORD, STATUS_OK, tbl_target[i], tbl_min[i], q[63:0],
                        tbl_max[i], 1'b0};
                  expected_results.push_back(r);
                  n++;
               end
               tbl_count[i] = 0;
            end
            if (n > 0) expected_results[$].last = 1'b1;
         end
      endcase
   endtask

   // driver: one word in flight, start dropped after each accept
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (start && !busy) begin
         predict_word('{req_cmd, req_source_id, req_sample_bits, req_sensor_type,
                        req_target_id});
         start <= 0;
         if (pending_words.size() > 40 && $urandom_range(0, 3) == 0)
            gap_left = $urandom_range(1, 17);
      end else if (!start) begin
         if (gap_left > 0) gap_left--;
         else if (pending_words.size() > 0) begin
            word_type w;
            w = pending_words.pop_front();
            req_cmd <= w.cmd;
            req_source_id <= w.source_id;
            req_sample_bits <= w.sample_bits;
            req_sensor_type <= w.sensor_type;
            req_target_id <= w.target_id;
            start <= 1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: kind %0d out_id %0h", rsp_kind, rsp_out_id);
            failures++;
         end else begin
            result_type e;
            e = expected_results.pop_front();
            if (rsp_kind !== e.kind) begin
               $error("kind: expected %0d actual %0d", e.kind, rsp_kind); failures++;
            end
            if (rsp_status !== e.status) begin
               $error("status: expected %0d actual %0d", e.status, rsp_status); failures++;
            end
            if (rsp_out_id !== e.out_id) begin
               $error("out_id: expected %0h actual %0h", e.out_id, rsp_out_id); failures++;
            end
            if (rsp_min_value !== e.min_value) begin
               $error("min_value: expected %0d actual %0d", $signed(e.min_value),
                      $signed(rsp_min_value)); failures++;
            end
            if (rsp_avg_value !== e.avg_value) begin
               $error("avg_value: expected %0d actual %0d", $signed(e.avg_value),
                      $signed(rsp_avg_value)); failures++;
            end
            if (rsp_max_value !== e.max_value) begin
               $error("max_value: expected %0d actual %0d", $signed(e.max_value),
                      $signed(rsp_max_value)); failures++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d actual %0d", e.last, rsp_last); failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic add_word(logic [1:0] c, logic [31:0] id, logic [63:0] b, logic [2:0] t,
                           logic [31:0] tg);
      pending_words.push_back('{c, id, b, t, tg});
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] edge_bits();
      case ($urandom_range(0, 7))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7FFF_FFFF_FFFF_FFFF;
         2: return 64'hFFFF_FFFF_FFFF_FFFF;
         3: return 64'h0000_0000_8000_0000;
         4: return 64'h0;
         default: return rand64();
      endcase
   endfunction

   initial begin
      int id_pool[20];
      int pick;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_valid[i] = 0;
         tbl_count[i] = 0;
      end
      for (int i = 0; i < 20; i++) id_pool[i] = (i == 19) ? 32'hFFFF_FFFF : $urandom_range(1, 40);
      id_pool[0] = 1;
      id_pool[1] = 2;
      id_pool[2] = 3;
      id_pool[3] = 32'hFFFF_FFFF;
      // directed part
      add_word(CMD_TICK, 0, 0, 0, 0);                                  // tick, empty table
      add_word(CMD_SET, 0, 0, 0, 32'h1234);                            // zero id rejected
      add_word(CMD_SET, 1, 0, 0, 32'hFFFF_FFFF);                       // int32
      add_word(CMD_SET, 2, 0, 1, 32'h0000_0002);                       // uint32
      add_word(CMD_SET, 3, 0, 2, 32'h0000_0003);                       // int64
      add_word(CMD_SET, 32'hFFFF_FFFF, 0, 3, 32'h0);                   // uint64
      add_word(CMD_SAMPLE, 1, 64'hFFFF_FFFF_8000_0000, 0, 0);
      add_word(CMD_SAMPLE, 1, 64'h0000_0000_7FFF_FFFF, 0, 0);
      add_word(CMD_SAMPLE, 2, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
      add_word(CMD_SAMPLE, 3, 64'h8000_0000_0000_0000, 0, 0);
      add_word(CMD_SAMPLE, 3, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
      add_word(CMD_SAMPLE, 3, 64'hFFFF_FFFF_FFFF_FFFD, 0, 0);
      add_word(CMD_SAMPLE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0); // saturates
      add_word(CMD_SAMPLE, 32'hFFFF_FFFF, 64'h0000_0000_0000_0005, 0, 0);
      add_word(CMD_SAMPLE, 77, 64'h5, 0, 0);                           // unknown id ignored
      add_word(CMD_SET, 2, 0, 2, 32'hABCD);                            // retype keeps data
      add_word(CMD_TICK, 0, 0, 0, 0);
      add_word(CMD_SET, 3, 0, 5, 0);                                   // type five removes
      add_word(CMD_SET, 99, 0, 4, 0);                                  // remove unknown
      for (int i = 0; i < 14; i++) add_word(CMD_SET, 100 + i, 0, 7, 0); // noise removes
      for (int i = 0; i < 14; i++) add_word(CMD_SET, 200 + i, 0, 2, i); // fill the table
      add_word(CMD_SET, 300, 0, 0, 0);                                 // table full
      add_word(CMD_CLEAR, 0, 0, 0, 0);
      // random part
      for (int n = 0; n < 360; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60)
            add_word(CMD_SAMPLE, ($urandom_range(0, 30) == 0) ? $urandom()
                     : id_pool[$urandom_range(0, 19)], edge_bits(), $urandom_range(0, 7),
                     $urandom());
         else if (pick < 85)
            add_word(CMD_SET, ($urandom_range(0, 20) == 0) ? ($urandom_range(0, 1) ? 0 : $urandom())
                     : id_pool[$urandom_range(0, 19)], rand64(),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 3),
                     $urandom());
         else if (pick < 88)
            add_word(CMD_CLEAR, $urandom(), rand64(), $urandom_range(0, 7), $urandom());
         else
            add_word(CMD_TICK, $urandom(), rand64(), $urandom_range(0, 7), $urandom());
      end
      add_word(CMD_TICK, 0, 0, 0, 0);
      repeat (8) @(posedge clock);
      reset <= 0;
      do @(posedge clock);
      while (pending_words.size() > 0 || start || busy || expected_results.size() > 0);
      repeat (2000) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         if (expected_results.size() > 0) $error("results still expected at the end");
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
